// ----- rtl/core/bce_pkg.sv -----
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, constants and the exponent table of the Bezier evaluator.
// ----------------------------------------------------------------------------
package bce_pkg;

	localparam int COORD_W   = 16;
	localparam int PIDX_W    = 4;
	localparam int T_W       = 15;
	localparam int EXP_W     = 16;
	localparam int CNT_CFG_W = 5;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 16;

	localparam int DEF_MAX_POINTS = 16;

	localparam logic [T_W-1:0]       ONE_T   = T_W'(16384);
	localparam logic [EXP_W-1:0]     ONE_EXP = EXP_W'(4096);
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SHAPING_EXP = CFG_IDX_W'(1);

	localparam logic             CMD_LOAD = 1'b0;
	localparam logic             CMD_EVAL = 1'b1;

	// Control from the sequencer to each coordinate lane.
	typedef struct packed {
		logic              load;
		logic [PIDX_W-1:0] load_idx;
		logic              start;
	} lane_ctrl_t;

	typedef logic [30:0] c_tab_t [16];

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v   = v_in;
		res = '0;
		for (int i = 0; i < 32; i++) begin
			b = 64'd1 << (62 - 2 * i);
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	// Entry k-1 holds 2^(-2^-k) in Q30, each the square root of the one before.
	function automatic c_tab_t calc_c_tab();
		c_tab_t      tab;
		logic [63:0] c;
		c = 64'd1 << 29;
		for (int k = 0; k < 16; k++) begin
			c      = isqrt64(c << 30);
			tab[k] = c[30:0];
		end
		return tab;
	endfunction

	localparam c_tab_t C_TAB = calc_c_tab();

endpackage

// ----- rtl/core/bezier_curve_evaluator.sv -----
// ----------------------------------------------------------------------------
// bezier_curve_evaluator
// Two-dimensional Bezier curve evaluation by de Casteljau reduction, with an
// x lane and a y lane side by side and an optional power shaping of t.
//
// Channel   Signals                                        Direction
// command   start, busy, command, point_index, point_x,
//           point_y, t_param                               in; busy out
// result    result_valid, curve_x, curve_y                 out
// config    cfg_write, cfg_index, cfg_data                 in
//
// A load beat writes a point and is followed by no result. An evaluate beat
// skips the shaper's iteration for exponent 1.0, t at zero or t at one, and
// otherwise runs 16 squarings, one multiply, 16 table multiplies and one shift;
// the reduction lanes then take the n points, one interpolator per lane.
// busy is high until the result strobe. Reset clears the control
// state and registers; the point store holds nothing defined until loaded.
// ----------------------------------------------------------------------------
module bezier_curve_evaluator #(
	parameter int MAX_POINTS = bce_pkg::DEF_MAX_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                command,
	input  logic [bce_pkg::PIDX_W-1:0]          point_index,
	input  logic signed [bce_pkg::COORD_W-1:0]  point_x,
	input  logic signed [bce_pkg::COORD_W-1:0]  point_y,
	input  logic signed [bce_pkg::COORD_W-1:0]  t_param,
	output logic                                result_valid,
	output logic signed [bce_pkg::COORD_W-1:0]  curve_x,
	output logic signed [bce_pkg::COORD_W-1:0]  curve_y,
	input  logic                                cfg_write,
	input  logic [bce_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bce_pkg::CFG_W-1:0]           cfg_data
);

	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int CW    = (CNT_W > bce_pkg::CNT_CFG_W) ? CNT_W : bce_pkg::CNT_CFG_W;

	typedef enum logic [1:0] {S_IDLE, S_SHAPE, S_REDUCE} state_t;

	state_t                            state_q;
	logic [bce_pkg::CNT_CFG_W-1:0]     count_q;
	logic [bce_pkg::EXP_W-1:0]         expo_q;
	logic [bce_pkg::T_W-1:0]           t_q;
	logic                              shape_go_q;
	logic [CNT_W-1:0]                  n_q;

	logic                              accept;
	logic [bce_pkg::T_W-1:0]           t_clamp;
	logic                              shape_done;
	logic [bce_pkg::T_W-1:0]           shape_t;
	logic [CW-1:0]                     cnt_ext;
	logic [CNT_W-1:0]                  n_sat;
	bce_pkg::lane_ctrl_t               ctrl;
	logic                              done_x;
	logic                              done_y;
	logic signed [15:0]                res_x;
	logic signed [15:0]                res_y;

	always_comb begin
		accept = start && !busy;
		if (t_param < 0) t_clamp = '0;
		else if (t_param > $signed(16'(bce_pkg::ONE_T))) t_clamp = bce_pkg::ONE_T;
		else t_clamp = t_param[bce_pkg::T_W-1:0];
		cnt_ext = CW'(count_q);
		if (cnt_ext == '0) n_sat = CNT_W'(1);
		else if (cnt_ext > CW'(MAX_POINTS)) n_sat = CNT_W'(MAX_POINTS);
		else n_sat = cnt_ext[CNT_W-1:0];
		ctrl.load     = accept && (command == bce_pkg::CMD_LOAD);
		ctrl.load_idx = point_index;
		ctrl.start    = (state_q == S_SHAPE) && shape_done;
	end

	assign busy = (state_q != S_IDLE);

	bce_shaper u_shaper (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (shape_go_q),
		.t_in   (t_q),
		.expo   (expo_q),
		.done   (shape_done),
		.t_out  (shape_t)
	);

	bce_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_data (point_x),
		.count     (n_q),
		.t_val     (shape_t),
		.done      (done_x),
		.result    (res_x)
	);

	bce_lane #(.MAX_POINTS(MAX_POINTS)) u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.load_data (point_y),
		.count     (n_q),
		.t_val     (shape_t),
		.done      (done_y),
		.result    (res_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= bce_pkg::CNT_CFG_W'(1);
			expo_q       <= bce_pkg::ONE_EXP;
			t_q          <= '0;
			n_q          <= '0;
			shape_go_q   <= 1'b0;
			result_valid <= 1'b0;
			curve_x      <= '0;
			curve_y      <= '0;
		end else begin
			shape_go_q   <= 1'b0;
			result_valid <= 1'b0;
			if (cfg_write) begin
				unique case (cfg_index)
					bce_pkg::REG_POINT_COUNT: count_q <= cfg_data[bce_pkg::CNT_CFG_W-1:0];
					bce_pkg::REG_SHAPING_EXP: expo_q  <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && command == bce_pkg::CMD_EVAL) begin
						t_q        <= t_clamp;
						n_q        <= n_sat;
						shape_go_q <= 1'b1;
						state_q    <= S_SHAPE;
					end
				end
				S_SHAPE: begin
					if (shape_done) state_q <= S_REDUCE;
				end
				S_REDUCE: begin
					// Both lanes run in lockstep; merge their points into one beat.
					if (done_x && done_y) begin
						curve_x      <= res_x;
						curve_y      <= res_y;
						result_valid <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/bce_shaper.sv -----
// ----------------------------------------------------------------------------
// bce_shaper
// Raises the clamped curve parameter to the Q4.12 shaping power through an
// iterative log2 by squaring and a table-driven power of two.
// ----------------------------------------------------------------------------
module bce_shaper (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bce_pkg::T_W-1:0]      t_in,
	input  logic [bce_pkg::EXP_W-1:0]    expo,
	output logic                         done,
	output logic [bce_pkg::T_W-1:0]      t_out
);

	typedef enum logic [2:0] {S_IDLE, S_SQ, S_MUL, S_EXP, S_FIN} state_t;

	state_t      state_q;
	logic [3:0]  cnt_q;
	logic [31:0] x_q;
	logic [15:0] frac_q;
	logic [3:0]  p_q;
	logic [23:0] m_q;
	logic [30:0] r_q;
	logic [15:0] e_q;

	logic [3:0]  p;
	logic [63:0] sq;
	logic [31:0] y;
	logic [20:0] nl;
	logic [36:0] mprod;
	logic [61:0] rprod;
	logic [7:0]  ip;
	logic [30:0] rsh;

	always_comb begin
		p = '0;
		for (int k = 0; k < 14; k++) begin
			if (t_in[k]) p = 4'(k);
		end
		sq    = 64'(x_q) * 64'(x_q);
		y     = sq[61:30];
		nl    = 21'((5'd14 - {1'b0, p_q}) * 21'd65536) - 21'(frac_q);
		mprod = 37'(nl) * 37'(e_q);
		rprod = 62'(r_q) * 62'(bce_pkg::C_TAB[cnt_q]);
		ip    = m_q[23:16];
		rsh   = r_q >> (6'd16 + {1'b0, ip[4:0]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			t_out   <= '0;
			cnt_q   <= '0;
			x_q     <= '0;
			frac_q  <= '0;
			p_q     <= '0;
			m_q     <= '0;
			r_q     <= '0;
			e_q     <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						e_q <= expo;
						if (expo == bce_pkg::ONE_EXP) begin
							t_out <= t_in;
							done  <= 1'b1;
						end else if (t_in >= bce_pkg::ONE_T) begin
							t_out <= bce_pkg::ONE_T;
							done  <= 1'b1;
						end else if (t_in == '0) begin
							t_out <= (expo == '0) ? bce_pkg::ONE_T : '0;
							done  <= 1'b1;
						end else begin
							x_q     <= 32'(t_in) << (5'd30 - {1'b0, p});
							p_q     <= p;
							frac_q  <= '0;
							cnt_q   <= '0;
							state_q <= S_SQ;
						end
					end
				end
				S_SQ: begin
					// One fraction bit of the logarithm per squaring.
					if (y[31]) begin
						x_q    <= {1'b0, y[31:1]};
						frac_q <= {frac_q[14:0], 1'b1};
					end else begin
						x_q    <= y;
						frac_q <= {frac_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= S_MUL;
				end
				S_MUL: begin
					m_q     <= mprod[35:12];
					r_q     <= 31'd1 << 30;
					cnt_q   <= '0;
					state_q <= S_EXP;
				end
				S_EXP: begin
					if (m_q[4'd15 - cnt_q]) r_q <= rprod[60:30];
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) state_q <= S_FIN;
				end
				S_FIN: begin
					t_out   <= (ip > 8'd30) ? '0 : rsh[bce_pkg::T_W-1:0];
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/core/bce_lane.sv -----
// ----------------------------------------------------------------------------
// bce_lane
// One coordinate lane: control point store and a de Casteljau reduction
// over a shift queue with one interpolator.
// ----------------------------------------------------------------------------
module bce_lane #(
	parameter int MAX_POINTS = bce_pkg::DEF_MAX_POINTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bce_pkg::lane_ctrl_t                 ctrl,
	input  logic signed [bce_pkg::COORD_W-1:0]  load_data,
	input  logic [$clog2(MAX_POINTS+1)-1:0]     count,
	input  logic [bce_pkg::T_W-1:0]             t_val,
	output logic                                done,
	output logic signed [bce_pkg::COORD_W-1:0]  result
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	logic signed [bce_pkg::COORD_W-1:0] store_q [MAX_POINTS];
	logic signed [bce_pkg::COORD_W-1:0] sh_q [MAX_POINTS];
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] step_q;
	logic             busy_q;

	logic [IDX_W+bce_pkg::PIDX_W-1:0] widx_ext;
	logic [IDX_W-1:0]                 widx;
	logic                             win;
	logic [CNT_W-1:0]                 last;
	logic [IDX_W-1:0]                 tail;
	logic signed [16:0]               diff;
	logic signed [32:0]               prod;
	logic signed [33:0]               acc;
	logic signed [15:0]               lerp;

	always_comb begin
		widx_ext = {{IDX_W{1'b0}}, ctrl.load_idx};
		widx     = widx_ext[IDX_W-1:0];
		win      = widx_ext < (IDX_W + bce_pkg::PIDX_W)'(MAX_POINTS);
		last     = len_q - CNT_W'(1);
		tail     = last[IDX_W-1:0];
		// a + (b - a) * t, rounded half up.
		diff = {sh_q[1][15], sh_q[1]} - {sh_q[0][15], sh_q[0]};
		prod = diff * $signed({1'b0, t_val});
		acc  = $signed({{4{sh_q[0][15]}}, sh_q[0], 14'd0}) + {prod[32], prod}
			+ 34'sd8192;
		lerp = acc[29:14];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load && win) store_q[widx] <= load_data;
		if (ctrl.start) begin
			for (int i = 0; i < MAX_POINTS; i++) sh_q[i] <= store_q[i];
		end else if (busy_q) begin
			for (int i = 0; i < MAX_POINTS - 1; i++) sh_q[i] <= sh_q[i + 1];
			if (step_q != last) sh_q[tail] <= lerp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			len_q  <= '0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctrl.start) begin
				len_q  <= count;
				step_q <= '0;
				if (count == CNT_W'(1)) done <= 1'b1;
				else busy_q <= 1'b1;
			end else if (busy_q) begin
				if (step_q == last) begin
					// The last beat of a round drops the spent head entry.
					len_q  <= last;
					step_q <= '0;
					if (last == CNT_W'(1)) begin
						busy_q <= 1'b0;
						done   <= 1'b1;
					end
				end else begin
					step_q <= step_q + CNT_W'(1);
				end
			end
		end
	end

	assign result = sh_q[0];

endmodule
